// ----- rtl/core/rrqs_pkg.sv -----
// Shared types and constants of the round-robin quantum scheduler.
// No dependencies; the controller, datapath and top level import this package.
package rrqs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TERM_W = 4;
  localparam int ID_W = 4;
  localparam int TICK_W = 32;
  localparam int QUANT_W = 16;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;
  localparam logic [PADDR_W-1:0] ADDR_QUANTUM = 2'd0;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CREATE = 2'd1,
    ACT_KILL   = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REFUSED   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UPDATE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   task_id;
    logic [TERM_W-1:0] terminal_number;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   reported_task;
    logic [TICK_W-1:0] run_ticks;
    logic              switched;
    logic [TERM_W-1:0] current_terminal;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic count;
    logic query;
    logic kill;
    logic scan_start;
    logic scan_step;
    logic scan_hit;
    logic scan_miss;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_t action;
    logic    gone;
    logic    expire;
    logic    hit;
    logic    scan_last;
    logic    out_free;
  } sts_t;

endpackage

// ----- rtl/core/rrqs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rrqs_ctrl.sv -----
// Sequencer of the scheduler: one word at a time through exec, update, scan, finish.
// Depends on rrqs_pkg.
module rrqs_ctrl import rrqs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.action)
          ACT_TICK: begin
            if (sts.gone) begin
              cmd.scan_start = 1'b1;
              state_next = S_SCAN;
            end else begin
              state_next = S_UPDATE;
            end
          end
          ACT_CREATE: begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
          ACT_KILL: begin
            cmd.kill = 1'b1;
            state_next = S_FINISH;
          end
          default: begin
            state_next = S_UPDATE;
          end
        endcase
      end
      S_UPDATE: begin
        if (sts.action == ACT_TICK) begin
          cmd.count = 1'b1;
          if (sts.expire) begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          cmd.query = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.scan_hit = 1'b1;
          state_next = S_FINISH;
        end else if (sts.scan_last) begin
          cmd.scan_miss = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/rrqs_dpath.sv -----
// Datapath of the scheduler: slot table, run-time RAM, ring scan and result register.
// Depends on rrqs_pkg and rrqs_ram.
module rrqs_dpath import rrqs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  in_t                item,
  input  logic [QUANT_W-1:0] quantum_length,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               result_valid,
  input  logic               result_ready,
  output out_t               result
);

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] slot);
    ring_next = (slot == SLOT_W'(MAX_TASKS - 1)) ? '0 : slot + SLOT_W'(1);
  endfunction

  // Control state
  logic [MAX_TASKS-1:0] live;
  logic [MAX_TASKS-1:0] rt_valid;
  logic [TERM_W-1:0]    term_q [MAX_TASKS];
  logic [SLOT_W-1:0]    cur;
  logic [SLOT_W-1:0]    tail;
  logic [QUANT_W-1:0]   ql;
  logic                 gone;

  // Payload
  in_t                item_q;
  logic [SLOT_W-1:0]  scan_slot;
  logic [CNT_W-1:0]   scan_left;
  status_t            res_status;
  logic [TICK_W-1:0]  res_ticks;
  logic               res_sw;
  logic               res_created;
  logic [SLOT_W-1:0]  res_new;
  logic               rd_valid;

  action_t            act;
  logic [SLOT_W-1:0]  id_slot;
  logic               id_ok;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [TICK_W-1:0]  ram_rdata;
  logic [TICK_W-1:0]  rt_now;
  logic [QUANT_W-1:0] reload;
  logic               hit;

  assign act       = action_t'(item_q.action);
  assign id_slot   = SLOT_W'(item_q.task_id);
  assign id_ok     = (32'(item_q.task_id) < 32'(MAX_TASKS)) && live[id_slot];
  assign ram_raddr = (act == ACT_QUERY) ? id_slot : cur;
  // Never-written entries read as zero.
  assign rt_now    = rd_valid ? ram_rdata : '0;
  assign reload    = (quantum_length == '0) ? QUANT_W'(1) : quantum_length;
  assign hit       = (scan_slot != '0) &&
                     ((act == ACT_CREATE) ? !live[scan_slot] : live[scan_slot]);

  assign sts.action    = act;
  assign sts.gone      = gone;
  assign sts.expire    = (ql <= QUANT_W'(1));
  assign sts.hit       = hit;
  assign sts.scan_last = (scan_left == CNT_W'(1));
  assign sts.out_free  = !result_valid || result_ready;

  rrqs_ram #(
    .WIDTH (TICK_W),
    .DEPTH (MAX_TASKS)
  ) u_run_time (
    .clk   (clk),
    .we    (cmd.count),
    .waddr (cur),
    .wdata (rt_now + TICK_W'(1)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      live         <= MAX_TASKS'(1);
      rt_valid     <= '0;
      cur          <= '0;
      tail         <= '0;
      ql           <= QUANTUM_RESET;
      gone         <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        term_q[i] <= '0;
      end
    end else begin
      if (cmd.count) begin
        rt_valid[cur] <= 1'b1;
        if (!sts.expire) begin
          ql <= ql - QUANT_W'(1);
        end
      end
      if (cmd.kill && id_ok && (item_q.task_id != '0)) begin
        live[id_slot] <= 1'b0;
        if (id_slot == cur) begin
          gone <= 1'b1;
        end
      end
      if (cmd.scan_hit) begin
        if (act == ACT_CREATE) begin
          live[scan_slot]     <= 1'b1;
          rt_valid[scan_slot] <= 1'b0;
          term_q[scan_slot]   <= item_q.terminal_number;
          tail                <= scan_slot;
        end else begin
          cur  <= scan_slot;
          gone <= 1'b0;
          ql   <= reload;
        end
      end
      if (cmd.scan_miss && (act != ACT_CREATE)) begin
        // Current task was killed and nothing else is live: fall back to idle.
        if (gone) begin
          cur <= '0;
        end
        gone <= 1'b0;
        ql   <= reload;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= rt_valid[ram_raddr];
    if (cmd.load) begin
      item_q      <= item;
      res_status  <= ST_OK;
      res_ticks   <= '0;
      res_sw      <= 1'b0;
      res_created <= 1'b0;
    end
    if (cmd.scan_start) begin
      scan_slot <= ring_next((act == ACT_CREATE) ? tail : cur);
      scan_left <= (act == ACT_CREATE) ? CNT_W'(MAX_TASKS) : CNT_W'(MAX_TASKS - 1);
    end
    if (cmd.scan_step) begin
      scan_slot <= ring_next(scan_slot);
      scan_left <= scan_left - CNT_W'(1);
    end
    if (cmd.scan_hit) begin
      if (act == ACT_CREATE) begin
        res_created <= 1'b1;
        res_new     <= scan_slot;
      end else begin
        res_sw <= 1'b1;
      end
    end
    if (cmd.scan_miss) begin
      if (act == ACT_CREATE) begin
        res_status <= ST_FULL;
      end else if (gone) begin
        res_sw <= 1'b1;
      end
    end
    if (cmd.kill) begin
      if (!id_ok) begin
        res_status <= ST_NOT_FOUND;
      end else if (item_q.task_id == '0) begin
        res_status <= ST_REFUSED;
      end
    end
    if (cmd.query) begin
      if (!id_ok) begin
        res_status <= ST_NOT_FOUND;
      end else begin
        res_ticks <= rt_now;
      end
    end
    if (cmd.emit) begin
      result.status           <= res_status;
      result.reported_task    <= ID_W'(res_created ? res_new : cur);
      result.run_ticks        <= res_ticks;
      result.switched         <= res_sw;
      result.current_terminal <= term_q[cur];
    end
  end

endmodule

// ----- rtl/core/round_robin_quantum_scheduler.sv -----
// Top level of the round-robin quantum scheduler: APB register, controller, datapath.
// Depends on rrqs_pkg, rrqs_ctrl and rrqs_dpath.
//
//   channel   direction  handshake                   word
//   item      in         item_valid / item_ready     in_t  (action, task_id, terminal_number)
//   result    out        result_valid / result_ready out_t (status ... current_terminal)
//   apb       in/out     psel, penable, pready=1     quantum_length at byte address 0
//
// One word is in work at a time. After the accepting edge, a kill passes through exec and
// finish; a query and a tick that does not expire pass through exec, update and finish. A
// tick whose quantum expires passes exec, update, the ring scan (at most MAX_TASKS-1 slots
// tested) and finish; a tick after its task was killed skips update, and a create passes
// exec, a scan of at most MAX_TASKS slots and finish. The finish step emits the result.
// Ready returns in the cycle the result turns valid.
// rst is synchronous and active high; it empties the table but for the idle slot
// and loads the quantum with its reset value of 10.
// A stalled result holds in the output register while the next word is accepted;
// that word waits in its finish step until the register is free.
module round_robin_quantum_scheduler import rrqs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  in_t                item,
  output logic               result_valid,
  input  logic               result_ready,
  output out_t               result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [QUANT_W-1:0] quantum_length;
  cmd_t               cmd;
  sts_t               sts;

  // Zero-wait APB slave; the register is written in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_QUANTUM) ? PDATA_W'(quantum_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_length <= QUANTUM_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_QUANTUM)) begin
      quantum_length <= pwdata[QUANT_W-1:0];
    end
  end

  // Sequence each word: decode, read run time, count or scan, deliver.
  rrqs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold the slot table, run times and current task; drive the result register.
  rrqs_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .quantum_length (quantum_length),
    .cmd            (cmd),
    .sts            (sts),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
  );

endmodule
